// ===== hw/rtl/array_list_cursor_engine_defines.svh =====
// Assertion macros for the array list cursor engine.
`ifndef ARRAY_LIST_CURSOR_ENGINE_DEFINES_SVH
`define ARRAY_LIST_CURSOR_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ALCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alce: same-cycle check failed");
`define ALCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alce: next-cycle check failed");
`else
`define ALCE_ASSERT_IMP(lbl, ante, cons)
`define ALCE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/alce_pkg.sv =====
// Shared types and codes of the array list cursor engine.
`default_nettype none

package alce_pkg;

    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t OP_APPEND = 2'd0;
    localparam func_t OP_FIRST  = 2'd1;
    localparam func_t OP_NEXT   = 2'd2;
    localparam func_t OP_REMOVE = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NO_ENTRY  = 2'd2;
    localparam status_t ST_NO_CURSOR = 2'd3;

    typedef struct packed {
        func_t                func;
        logic [IN_DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [OUT_DATA_W-1:0]  data_out;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count_out;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alce_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface alce_req_if import alce_pkg::*;;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface alce_rsp_if import alce_pkg::*;;
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/array_list_cursor_engine.sv =====
// Top level of the array list cursor engine: list control and response register.
//
//  channel | direction | payload                        | transaction when
//  req     | in        | func, data_in                  | req.valid && req.ready
//  rsp     | out       | data_out, status, count_out    | rsp.valid && rsp.ready
//
//  One request at a time. Append and every error go straight to finish, first and next
//  through the read state. Remove reads the head, then the shift moves one entry per
//  cycle through the single read and single write port of the entry memory.
//  Reset empties the list and clears the cursor; the memory is not cleared.
//  A stalled response waits in the output register while the next request is taken.
`default_nettype none
`include "array_list_cursor_engine_defines.svh"

module array_list_cursor_engine import alce_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    alce_req_if.sink  req,
    alce_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RM_HEAD,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]      cur_pos_reg, cur_pos_next;
    logic [CNT_W-1:0]      src_reg, src_next;
    logic [OUT_DATA_W-1:0] res_data_reg, res_data_next;
    status_t               res_status_reg, res_status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_payload_reg, rsp_payload_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                              req_fire;
    logic                              rsp_slot_free;
    logic [DATA_WIDTH+IN_DATA_W-1:0]   word_wide;
    logic [DATA_WIDTH+OUT_DATA_W-1:0]  rd_wide;
    logic [CNT_W+COUNT_OUT_W-1:0]      count_wide;
    logic [CNT_W-1:0]                  cur_wide;
    logic [CNT_W-1:0]                  next_pos;
    logic [CNT_W-1:0]                  src_inc;
    logic [CNT_W-1:0]                  src_dec;
    logic                              has_more;

    alce_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.payload   = rsp_payload_reg;
    assign rsp_slot_free = !rsp_valid_reg || rsp.ready;

    assign word_wide  = {{DATA_WIDTH{1'b0}}, req.payload.data_in};
    assign rd_wide    = {{OUT_DATA_W{1'b0}}, ram_rdata};
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign cur_wide   = CNT_W'(cur_pos_reg);
    assign next_pos   = cur_valid_reg ? (cur_wide + CNT_W'(1)) : '0;
    assign src_inc    = src_reg + CNT_W'(1);
    assign src_dec    = src_reg - CNT_W'(1);
    assign has_more   = (src_inc < count_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cur_valid_next   = cur_valid_reg;
        cur_pos_next     = cur_pos_reg;
        src_next         = src_reg;
        res_data_next    = res_data_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_payload_next = rsp_payload_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[IDX_W-1:0];
        ram_wdata        = word_wide[DATA_WIDTH-1:0];
        ram_re           = 1'b0;
        ram_raddr        = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                    case (req.payload.func)
                        OP_APPEND:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NO_ENTRY;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = '0;
                                cur_valid_next = 1'b1;
                                cur_pos_next   = '0;
                                state_next     = S_READ;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (next_pos >= count_reg)
                            begin
                                res_status_next = ST_NO_ENTRY;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = next_pos[IDX_W-1:0];
                                cur_valid_next = 1'b1;
                                cur_pos_next   = next_pos[IDX_W-1:0];
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            if (!cur_valid_reg || (cur_wide >= count_reg))
                            begin
                                res_status_next = ST_NO_CURSOR;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cur_pos_reg;
                                src_next   = cur_wide;
                                state_next = S_RM_HEAD;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_data_next = rd_wide[OUT_DATA_W-1:0];
                state_next    = S_FINISH;
            end
            S_RM_HEAD, S_SHIFT:
            begin
                if (state_reg == S_RM_HEAD)
                begin
                    res_data_next = rd_wide[OUT_DATA_W-1:0];
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = src_dec[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (has_more)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = src_inc[IDX_W-1:0];
                    src_next   = src_inc;
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (cur_pos_reg == '0)
                    begin
                        cur_valid_next = 1'b0;
                    end
                    else
                    begin
                        cur_pos_next = cur_pos_reg - IDX_W'(1);
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_slot_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_payload_next.data_out  = res_data_reg;
                    rsp_payload_next.status    = res_status_reg;
                    rsp_payload_next.count_out = count_wide[COUNT_OUT_W-1:0];
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            cur_valid_reg   <= 1'b0;
            cur_pos_reg     <= '0;
            src_reg         <= '0;
            res_data_reg    <= '0;
            res_status_reg  <= ST_OK;
            rsp_valid_reg   <= 1'b0;
            rsp_payload_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            cur_valid_reg   <= cur_valid_next;
            cur_pos_reg     <= cur_pos_next;
            src_reg         <= src_next;
            res_data_reg    <= res_data_next;
            res_status_reg  <= res_status_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_payload_reg <= rsp_payload_next;
        end
    end

    `ALCE_ASSERT_IMP(a_cursor_below_count, cur_valid_reg, cur_wide < count_reg)
    `ALCE_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != S_IDLE)
    `ALCE_ASSERT_IMP(a_shift_source_in_range, state_reg == S_SHIFT, src_reg < count_reg)
    `ALCE_ASSERT_IMP(a_count_bounded, rsp_valid_reg, count_reg <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== hw/rtl/alce_ram.sv =====
// Simple dual-port entry memory with registered read data.
`default_nettype none

module alce_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
